// ----- design/resp_pkg.sv -----
// Package for the reply stream parser: field widths, event and fault codes,
// line kind codes and the byte constants. No dependencies.
`timescale 1ns / 1ps
package resp_pkg;
    localparam int MAX_NEST_DEF   = 8;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [2:0] EV_STR_BYTE = 3'd0;
    localparam logic [2:0] EV_ERR_BYTE = 3'd1;
    localparam logic [2:0] EV_BULK_BYTE = 3'd2;
    localparam logic [2:0] EV_STR_END  = 3'd3;
    localparam logic [2:0] EV_INTEGER  = 3'd4;
    localparam logic [2:0] EV_ARRAY    = 3'd5;
    localparam logic [2:0] EV_NULL     = 3'd6;
    localparam logic [2:0] EV_FAULT    = 3'd7;

    localparam logic [2:0] FC_NONE     = 3'd0;
    localparam logic [2:0] FC_BAD_TYPE = 3'd1;
    localparam logic [2:0] FC_NO_DIG   = 3'd2;
    localparam logic [2:0] FC_OVERFLOW = 3'd3;
    localparam logic [2:0] FC_NEG_SIZE = 3'd4;
    localparam logic [2:0] FC_BAD_DELIM = 3'd5;
    localparam logic [2:0] FC_TOO_BIG  = 3'd6;

    localparam logic [2:0] LK_SIMPLE = 3'd0;
    localparam logic [2:0] LK_ERROR  = 3'd1;
    localparam logic [2:0] LK_INT    = 3'd2;
    localparam logic [2:0] LK_BULK   = 3'd3;
    localparam logic [2:0] LK_ARRAY  = 3'd4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  byte_value;
        logic [63:0] number;
        logic [3:0]  nest_level;
        logic        reply_done;
        logic [2:0]  fault_code;
    } t_result;
endpackage

// ----- design/resp_if.sv -----
// Valid/ready channel interfaces for input bytes and result beats.
// No dependencies.
`timescale 1ns / 1ps
interface resp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface resp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  byte_value;
    logic signed [63:0] number;
    logic [3:0]  nest_level;
    logic        reply_done;
    logic [2:0]  fault_code;
    modport source (output valid, output event_res, output byte_value, output number,
                    output nest_level, output reply_done, output fault_code, input ready);
    modport sink   (input valid, input event_res, input byte_value, input number,
                    input nest_level, input reply_done, input fault_code, output ready);
endinterface

// ----- design/resp_reply_stream_parser.sv -----
// Top level of the reply stream parser: byte decode, array stack and output skid.
// Depends on resp_pkg and resp_if.
`timescale 1ns / 1ps
// One input byte per cycle; each beat is decoded in the cycle it is accepted
// and its event, if any, lands in a one-deep output register with a skid
// entry, so input stalls only when both hold unread events. Array nesting is
// tracked with MAX_NEST count registers; a finished element closes at once
// every level whose count would hit zero by a parallel compare of all levels.
// After a fault all bytes are dropped until reset.
module resp_reply_stream_parser #(
    parameter int MAX_NEST   = resp_pkg::MAX_NEST_DEF,
    parameter int COUNT_BITS = resp_pkg::COUNT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    resp_in_if.sink    i_in,
    resp_out_if.source o_out
);
    localparam int LW = $clog2(MAX_NEST + 1);
    localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    localparam logic [3:0] PH_TYPE = 4'd0;
    localparam logic [3:0] PH_LINE = 4'd1;
    localparam logic [3:0] PH_SKIP = 4'd2;
    localparam logic [3:0] PH_BULK = 4'd3;
    localparam logic [3:0] PH_DCR  = 4'd4;
    localparam logic [3:0] PH_DLF  = 4'd5;

    localparam logic [1:0] DG_NONE = 2'd0;
    localparam logic [1:0] DG_RUN  = 2'd1;
    localparam logic [1:0] DG_DONE = 2'd2;
    localparam logic [1:0] DG_FAIL = 2'd3;

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_kind, n_kind;
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [1:0]  r_dig, n_dig;
    logic [2:0]  r_pfault, n_pfault;
    logic [COUNT_BITS-1:0] r_bulk, n_bulk;
    logic [COUNT_BITS-1:0] r_cnt [MAX_NEST];
    logic [LW-1:0] r_top, n_top;
    logic        r_halt, n_halt;

    // output register plus skid entry
    resp_pkg::t_result r_out, r_skid;
    logic r_out_v, r_skid_v;

    logic accept;
    logic emit;
    resp_pkg::t_result res;
    logic push;
    logic [COUNT_BITS-1:0] push_val;
    logic pop_en;
    logic [LW-1:0] top_after;

    assign i_in.ready = !r_skid_v;
    assign accept = i_in.valid && i_in.ready;

    // number feed helpers
    logic [7:0]  b;
    logic        is_digit;
    logic [3:0]  dval;
    logic [63:0] limit, acc10;
    logic        ovf;
    logic [63:0] mag_max;

    assign b = i_in.data_byte;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign dval = b[3:0] - 4'd0;
    assign limit = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    assign acc10 = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0};
    // overflow if acc*10+d > limit; acc above limit/10 always overflows
    assign ovf = (r_acc > 64'd922337203685477580) ||
                 (acc10 > limit - {60'd0, dval});
    assign mag_max = {{(64-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    // close levels: level i (below top) closes when all from it up to top are 1
    always_comb begin
        logic run;
        run = 1'b1;
        top_after = r_top;
        for (int i = MAX_NEST - 1; i >= 0; i--) begin
            if (i < int'(r_top)) begin
                if (run && r_cnt[i] == {{(COUNT_BITS-1){1'b0}}, 1'b1})
                    top_after = LW'(i);
                else
                    run = 1'b0;
            end
        end
    end

    always_comb begin
        logic [LW-1:0] lvl4;
        n_phase = r_phase; n_kind = r_kind; n_acc = r_acc; n_neg = r_neg;
        n_dig = r_dig; n_pfault = r_pfault; n_bulk = r_bulk; n_top = r_top;
        n_halt = r_halt;
        emit = 1'b0; push = 1'b0; pop_en = 1'b0;
        push_val = r_acc[COUNT_BITS-1:0];
        lvl4 = r_top;
        res = '0;
        res.nest_level = 4'(lvl4);
        if (!r_halt) begin
            case (r_phase)
                PH_TYPE: begin
                    n_acc = '0; n_neg = 1'b0; n_dig = DG_NONE; n_pfault = resp_pkg::FC_NONE;
                    n_phase = PH_LINE;
                    case (b)
                        resp_pkg::CH_PLUS:   n_kind = resp_pkg::LK_SIMPLE;
                        resp_pkg::CH_MINUS:  n_kind = resp_pkg::LK_ERROR;
                        resp_pkg::CH_COLON:  n_kind = resp_pkg::LK_INT;
                        resp_pkg::CH_DOLLAR: n_kind = resp_pkg::LK_BULK;
                        resp_pkg::CH_STAR:   n_kind = resp_pkg::LK_ARRAY;
                        default: begin
                            n_phase = r_phase; n_acc = r_acc; n_neg = r_neg;
                            n_dig = r_dig; n_pfault = r_pfault;
                            emit = 1'b1; n_halt = 1'b1;
                            res.event_res = resp_pkg::EV_FAULT;
                            res.fault_code = resp_pkg::FC_BAD_TYPE;
                        end
                    endcase
                end
                PH_LINE: begin
                    if (b == resp_pkg::CH_CR) begin
                        n_phase = PH_SKIP;
                    end else if (r_kind <= resp_pkg::LK_ERROR) begin
                        emit = 1'b1;
                        res.event_res = r_kind;
                        res.byte_value = b;
                    end else if (r_dig == DG_NONE && !is_digit) begin
                        if (b == resp_pkg::CH_MINUS && !r_neg) begin
                            n_neg = 1'b1;
                        end else begin
                            n_dig = DG_FAIL; n_pfault = resp_pkg::FC_NO_DIG;
                        end
                    end else if (r_dig == DG_RUN && !is_digit) begin
                        n_dig = DG_DONE;
                    end else if (r_dig == DG_NONE || r_dig == DG_RUN) begin
                        if (ovf) begin
                            n_dig = DG_FAIL; n_pfault = resp_pkg::FC_OVERFLOW;
                        end else begin
                            n_acc = acc10 + {60'd0, dval};
                            n_dig = DG_RUN;
                        end
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_TYPE;
                    emit = 1'b1;
                    if (r_kind <= resp_pkg::LK_ERROR) begin
                        res.event_res = resp_pkg::EV_STR_END; pop_en = 1'b1;
                    end else if (r_dig == DG_NONE || r_dig == DG_FAIL) begin
                        res.event_res = resp_pkg::EV_FAULT; n_halt = 1'b1;
                        res.fault_code = (r_dig == DG_NONE) ? resp_pkg::FC_NO_DIG : r_pfault;
                    end else if (r_kind == resp_pkg::LK_INT) begin
                        res.event_res = resp_pkg::EV_INTEGER; pop_en = 1'b1;
                        res.number = r_neg ? (64'd0 - r_acc) : r_acc;
                    end else if (r_neg && r_acc == 64'd1) begin
                        res.event_res = resp_pkg::EV_NULL; pop_en = 1'b1;
                    end else if (r_neg && r_acc != 64'd0) begin
                        res.event_res = resp_pkg::EV_FAULT; n_halt = 1'b1;
                        res.fault_code = resp_pkg::FC_NEG_SIZE;
                    end else if (r_acc > mag_max) begin
                        res.event_res = resp_pkg::EV_FAULT; n_halt = 1'b1;
                        res.fault_code = resp_pkg::FC_TOO_BIG;
                    end else if (r_kind == resp_pkg::LK_BULK) begin
                        emit = 1'b0;
                        n_bulk = r_acc[COUNT_BITS-1:0];
                        n_phase = (r_acc == 64'd0) ? PH_DCR : PH_BULK;
                    end else if (r_acc == 64'd0) begin
                        res.event_res = resp_pkg::EV_ARRAY; pop_en = 1'b1;
                    end else if (int'(r_top) >= MAX_NEST) begin
                        res.event_res = resp_pkg::EV_FAULT; n_halt = 1'b1;
                        res.fault_code = resp_pkg::FC_TOO_BIG;
                    end else begin
                        res.event_res = resp_pkg::EV_ARRAY;
                        res.number = r_acc;
                        push = 1'b1;
                        n_top = r_top + LW'(1);
                    end
                end
                PH_BULK: begin
                    n_bulk = r_bulk - COUNT_BITS'(1);
                    if (n_bulk == '0) n_phase = PH_DCR;
                    emit = 1'b1;
                    res.event_res = resp_pkg::EV_BULK_BYTE;
                    res.byte_value = b;
                end
                PH_DCR: begin
                    if (b != resp_pkg::CH_CR) begin
                        emit = 1'b1; n_halt = 1'b1;
                        res.event_res = resp_pkg::EV_FAULT;
                        res.fault_code = resp_pkg::FC_BAD_DELIM;
                    end else begin
                        n_phase = PH_DLF;
                    end
                end
                PH_DLF: begin
                    emit = 1'b1;
                    if (b != resp_pkg::CH_LF) begin
                        n_halt = 1'b1;
                        res.event_res = resp_pkg::EV_FAULT;
                        res.fault_code = resp_pkg::FC_BAD_DELIM;
                    end else begin
                        n_phase = PH_TYPE;
                        res.event_res = resp_pkg::EV_STR_END;
                        pop_en = 1'b1;
                    end
                end
                default: n_phase = PH_TYPE;
            endcase
        end
        if (pop_en) begin
            n_top = top_after;
            res.reply_done = (top_after == '0);
        end
    end

    // push only happens below MAX_NEST, so the top index is always in range
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (push) r_cnt[IW'(r_top)] <= push_val;
            // the surviving top level loses one element
            if (pop_en && top_after != '0) r_cnt[IW'(top_after - LW'(1))] <=
                r_cnt[IW'(top_after - LW'(1))] - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE; r_kind <= '0; r_acc <= '0; r_neg <= 1'b0;
            r_dig <= DG_NONE; r_pfault <= '0; r_bulk <= '0; r_top <= '0;
            r_halt <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase; r_kind <= n_kind; r_acc <= n_acc; r_neg <= n_neg;
            r_dig <= n_dig; r_pfault <= n_pfault; r_bulk <= n_bulk; r_top <= n_top;
            r_halt <= n_halt;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || o_out.ready) begin
                if (r_skid_v) begin
                    r_out <= r_skid; r_out_v <= 1'b1; r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= accept && emit;
                    r_out <= res;
                end
            end else if (accept && emit) begin
                r_skid <= res; r_skid_v <= 1'b1;
            end
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.event_res  = r_out.event_res;
    assign o_out.byte_value = r_out.byte_value;
    assign o_out.number     = r_out.number;
    assign o_out.nest_level = r_out.nest_level;
    assign o_out.reply_done = r_out.reply_done;
    assign o_out.fault_code = r_out.fault_code;
endmodule
